// ===== rtl/ufmt_pkg.sv =====
// Shared types and constants for the unsigned decimal field formatter.
// Used by the front converter, the descriptor queue and the back emitter.
package ufmt_pkg;

  localparam int unsigned DIGITS  = 20;
  localparam int unsigned VALUE_W = 64;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_COUNT,
    F_PUSH
  } front_state_t;

  // One formatted field: leading fill, zero extension, digits, trailing spaces.
  typedef struct packed {
    logic [5:0] lead_count;
    logic [7:0] lead_char;
    logic [5:0] zero_count;
    logic [4:0] digit_count;
    bcd_t       digits;
    logic [5:0] trail_count;
    logic [6:0] total;
  } desc_t;

endpackage

// ===== rtl/unsigned_decimal_field_formatter.sv =====
// Top level of the unsigned decimal field formatter.
// Instantiates ufmt_front, ufmt_queue and ufmt_back; types from ufmt_pkg.
//
// An item (a 64-bit value and its field settings) is taken when start is high
// and busy is low. The converter holds busy while it runs the shift-and-add-3
// binary to decimal loop over all 64 value bits, counts the digits and
// classifies the field, and while it waits for a free slot in the two-entry
// descriptor queue. The next item can only be taken once the converter is back
// in idle, after its descriptor has been pushed. The emitter then drives one
// character per cycle while an item is being emitted, from 1 up to 64
// characters per item, reloading the next descriptor from the queue between
// items; conversion of the next item overlaps emission of the
// current one. Each character appears with strobe high for exactly one cycle
// and last marks the final character of an item. The receiver cannot stall:
// every strobed character must be taken in the cycle it is shown.
module unsigned_decimal_field_formatter #(
  parameter int unsigned MAX_FIELD = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [5:0]  field_width,
  input  logic [5:0]  min_digits,
  input  logic        precision_given,
  input  logic [5:0]  precision_value,
  input  logic        zero_pad,
  input  logic        left_justify,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);

  ufmt_pkg::desc_t push_data;
  ufmt_pkg::desc_t head;
  logic            push;
  logic            full;
  logic            pop;
  logic            empty;

  ufmt_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .field_width     (field_width),
    .min_digits      (min_digits),
    .precision_given (precision_given),
    .precision_value (precision_value),
    .zero_pad        (zero_pad),
    .left_justify    (left_justify),
    .full            (full),
    .push            (push),
    .desc            (push_data)
  );

  ufmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  ufmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

// ===== rtl/ufmt_front.sv =====
// Front part: accepts an item, converts the value to BCD with a shift-and-add-3
// loop and classifies the field into a descriptor. Depends on ufmt_pkg.
module ufmt_front #(
  parameter int unsigned MAX_FIELD = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ufmt_pkg::VALUE_W-1:0] value,
  input  logic [5:0]                   field_width,
  input  logic [5:0]                   min_digits,
  input  logic                         precision_given,
  input  logic [5:0]                   precision_value,
  input  logic                         zero_pad,
  input  logic                         left_justify,
  input  logic                         full,
  output logic                         push,
  output ufmt_pkg::desc_t              desc
);

  localparam logic [5:0] FIELD_CAP = (MAX_FIELD > 63) ? 6'd63 : 6'(MAX_FIELD);

  ufmt_pkg::front_state_t state, state_next;

  logic [ufmt_pkg::VALUE_W-1:0] value_sr;
  ufmt_pkg::bcd_t               bcd;
  logic [5:0]                   step;
  logic [5:0]                   w;
  logic [5:0]                   t;
  logic                         dot;
  logic                         prec_zero;
  logic                         zpad;
  logic                         left;
  logic [4:0]                   n;

  ufmt_pkg::bcd_t               bcd_adj;
  logic [4*ufmt_pkg::DIGITS-1:0] bcd_flat;
  logic [4:0]                   n_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufmt_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ufmt_pkg::F_IDLE:  if (start) state_next = ufmt_pkg::F_CONV;
      ufmt_pkg::F_CONV:  if (step == 6'd63) state_next = ufmt_pkg::F_COUNT;
      ufmt_pkg::F_COUNT: state_next = ufmt_pkg::F_PUSH;
      ufmt_pkg::F_PUSH:  if (!full) state_next = ufmt_pkg::F_IDLE;
      default:           state_next = ufmt_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    unique case (state)
      ufmt_pkg::F_IDLE: busy = 1'b0;
      ufmt_pkg::F_PUSH: push = !full;
      default:          busy = 1'b1;
    endcase
  end

  // Add 3 to every digit of five or more, then shift in the next value bit.
  always_comb begin
    bcd_adj = bcd;
    for (int k = 0; k < ufmt_pkg::DIGITS; k++) begin
      if (bcd[k] >= 4'd5) bcd_adj[k] = bcd[k] + 4'd3;
    end
    bcd_flat = bcd_adj;
  end

  // Digit count with value zero counted as no digits.
  always_comb begin
    n_found = 5'd0;
    for (int k = 0; k < ufmt_pkg::DIGITS; k++) begin
      if (bcd[k] != 4'd0) n_found = 5'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 6'd0;
    end else if (state == ufmt_pkg::F_IDLE && start) begin
      step <= 6'd0;
    end else if (state == ufmt_pkg::F_CONV) begin
      step <= step + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ufmt_pkg::F_IDLE && start) begin
      value_sr  <= value;
      bcd       <= '0;
      w         <= (field_width > FIELD_CAP) ? FIELD_CAP : field_width;
      t         <= (min_digits > FIELD_CAP) ? FIELD_CAP : min_digits;
      dot       <= precision_given;
      prec_zero <= (precision_value == 6'd0);
      zpad      <= zero_pad;
      left      <= left_justify;
    end else if (state == ufmt_pkg::F_CONV) begin
      bcd      <= ufmt_pkg::bcd_t'({bcd_flat[4*ufmt_pkg::DIGITS-2:0],
                                    value_sr[ufmt_pkg::VALUE_W-1]});
      value_sr <= {value_sr[ufmt_pkg::VALUE_W-2:0], 1'b0};
    end
    if (state == ufmt_pkg::F_COUNT) begin
      n <= n_found;
    end
  end

  logic [6:0] n7, t7, w7, m7, z7, nd7, lead7, zero7, trail7;
  logic [7:0] total8;

  always_comb begin
    n7  = {2'b00, n};
    t7  = {1'b0, t};
    w7  = {1'b0, w};
    nd7 = (n == 5'd0) ? 7'd1 : n7;
    m7  = (n7 > t7) ? n7 : t7;
    z7  = (t7 > n7) ? (t7 - n7) : 7'd0;
    if (!left) begin
      lead7  = (w7 > m7) ? (w7 - m7) : 7'd0;
      zero7  = dot ? z7 : 7'd0;
      trail7 = 7'd0;
    end else begin
      lead7  = 7'd0;
      zero7  = z7;
      trail7 = (w7 > (z7 + n7)) ? (w7 - z7 - n7) : 7'd0;
    end
    total8 = {1'b0, lead7} + {1'b0, zero7} + {1'b0, nd7} + {1'b0, trail7};

    desc.lead_count  = lead7[5:0];
    desc.lead_char   = (zpad || (t == 6'd0 && dot && prec_zero)) ?
                       ufmt_pkg::CHAR_ZERO : ufmt_pkg::CHAR_SPACE;
    desc.zero_count  = zero7[5:0];
    desc.digit_count = nd7[4:0];
    desc.digits      = bcd;
    desc.trail_count = trail7[5:0];
    desc.total       = total8[6:0];
  end

endmodule

// ===== rtl/ufmt_queue.sv =====
// Two-entry descriptor queue between the converter and the emitter.
// Depends on ufmt_pkg for the descriptor type.
module ufmt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ufmt_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output ufmt_pkg::desc_t head,
  output logic            empty
);

  ufmt_pkg::desc_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/ufmt_back.sv =====
// Back part: takes descriptors from the queue and emits one character per cycle while one is active.
// Depends on ufmt_pkg for the descriptor type and character codes.
module ufmt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  ufmt_pkg::desc_t head,
  output logic            pop,
  output logic            strobe,
  output logic [7:0]      character,
  output logic            last
);

  logic            active;
  ufmt_pkg::desc_t cur;

  logic [7:0] ch;
  logic       is_last;
  logic [4:0] didx;

  assign pop = !active && !empty;

  always_comb begin
    didx    = cur.digit_count - 5'd1;
    is_last = (cur.total == 7'd1);
    if (cur.lead_count != 6'd0) begin
      ch = cur.lead_char;
    end else if (cur.zero_count != 6'd0) begin
      ch = ufmt_pkg::CHAR_ZERO;
    end else if (cur.digit_count != 5'd0) begin
      ch = ufmt_pkg::CHAR_ZERO + {4'd0, cur.digits[didx]};
    end else begin
      ch = ufmt_pkg::CHAR_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (active && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (active) begin
      cur.total <= cur.total - 7'd1;
      if (cur.lead_count != 6'd0) begin
        cur.lead_count <= cur.lead_count - 6'd1;
      end else if (cur.zero_count != 6'd0) begin
        cur.zero_count <= cur.zero_count - 6'd1;
      end else if (cur.digit_count != 5'd0) begin
        cur.digit_count <= cur.digit_count - 5'd1;
      end else if (cur.trail_count != 6'd0) begin
        cur.trail_count <= cur.trail_count - 6'd1;
      end
    end
    if (active) begin
      character <= ch;
      last      <= is_last;
    end
  end

endmodule
